### rtl/dhcf_pkg.sv
package dhcf_pkg;

  localparam int unsigned CountWidth = 48;
  localparam int unsigned HashWidth  = 64;
  localparam int unsigned CountField = 48;
  localparam int unsigned RotAmount  = 23;

  localparam logic [HashWidth-1:0] FnvBasis = 64'd1469598103934665603;
  localparam logic [HashWidth-1:0] FnvPrime = 64'd1099511628211;
  localparam logic [HashWidth-1:0] Golden   = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [HashWidth-1:0] MixMult  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [HashWidth-1:0] MixInit  = FnvPrime;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  typedef logic [HashWidth-1:0]  hash_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef struct packed {
    hash_t                 combined_key;
    logic [CountField-1:0] pixel_byte_count;
    hash_t                 mix_hash;
    hash_t                 fnv_hash;
  } result_t;

  function automatic hash_t rotl(input hash_t v);
    rotl = (v << RotAmount) | (v >> (HashWidth - RotAmount));
  endfunction

endpackage

### rtl/dual_hash_content_fingerprint_top.sv
// Dual-hash content fingerprint.
// Input stream: one byte per transfer. s_axis_tdata carries data_byte,
// s_axis_tuser flags pixel bytes (counted, saturating), s_axis_tlast marks
// the final byte of an asset stream.
// Output stream: one transfer per asset, emitted for the byte marked last.
// m_axis_tdata carries fnv_hash, mix_hash, pixel_byte_count and combined_key.
// A byte is registered at the input, then hashed; the result for the byte
// marked last is registered once more and appears on m_axis.
// Throughput: one byte per cycle unless a last byte stalls; the FNV and mix
// state registers update once per byte through one constant multiply each.
// Reset: both hashes return to their seeds and the pixel count to zero; no
// result is pending. The same reinitialization follows every last byte.
// Stall: a held result blocks only a further last byte; ordinary bytes keep
// flowing into the hash state. s_axis_tready drops when a last byte waits
// in the input register behind an untaken result.
module dual_hash_content_fingerprint_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] is_pixel
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [239:0] m_axis_tdata    // [63:0] fnv_hash, [127:64] mix_hash,
                                       // [175:128] pixel_byte_count,
                                       // [239:176] combined_key
);
  import dhcf_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_pix_q;
  logic       in_last_q;

  hash_t   fnv_q, fnv_d;
  hash_t   mix_q, mix_d;
  count_t  cnt_q, cnt_d;
  logic    out_valid_q;
  result_t res_q, res_d;

  hash_t  mix_x;
  logic   out_free;
  logic   adv;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  always_comb begin
    mix_x = mix_q ^ (HashWidth'(in_byte_q) + Golden + (mix_q << 6) + (mix_q >> 2));
    fnv_d = (fnv_q ^ HashWidth'(in_byte_q)) * FnvPrime;
    mix_d = mix_x * MixMult;
    cnt_d = cnt_q;
    if (in_pix_q && (cnt_q != CountMax)) begin
      cnt_d = cnt_q + 1'b1;
    end
    res_d.fnv_hash         = fnv_d;
    res_d.mix_hash         = mix_d;
    res_d.pixel_byte_count = CountField'(cnt_d);
    res_d.combined_key     = fnv_d ^ rotl(mix_d) ^ (HashWidth'(cnt_d) * Golden);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_pix_q  <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fnv_q <= FnvBasis;
      mix_q <= MixInit;
      cnt_q <= '0;
    end else if (adv) begin
      if (in_last_q) begin
        fnv_q <= FnvBasis;
        mix_q <= MixInit;
        cnt_q <= '0;
      end else begin
        fnv_q <= fnv_d;
        mix_q <= mix_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> (fnv_q == FnvBasis && mix_q == MixInit && cnt_q == '0))
    else $error("hash state not reinitialized after last byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !in_last_q) |=> (cnt_q >= $past(cnt_q)))
    else $error("pixel count decreased within a stream");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_last_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(res_q))
    else $error("held result changed");
`endif

endmodule

### test/dual_hash_content_fingerprint_top_tb.sv
module dual_hash_content_fingerprint_top_tb;
  import dhcf_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomBytes  = 800;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned HoldOffStart = 300;
  localparam int unsigned HoldOffLen   = 400;

  class fingerprint_tracker;
    hash_t   fnv_state;
    hash_t   mix_state;
    count_t  pixel_total;
    result_t expected_prints[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      fnv_state   = FnvBasis;
      mix_state   = MixInit;
      pixel_total = '0;
    endfunction

    function void absorb(input logic [7:0] b, input logic pix, input logic last);
      hash_t   wide_b;
      result_t print;
      wide_b    = {56'd0, b};
      fnv_state = (fnv_state ^ wide_b) * FnvPrime;
      mix_state = mix_state ^ (wide_b + Golden + (mix_state << 6) + (mix_state >> 2));
      mix_state = mix_state * MixMult;
      if (pix && pixel_total != CountMax) begin
        pixel_total = pixel_total + 1'b1;
      end
      if (last) begin
        print.fnv_hash         = fnv_state;
        print.mix_hash         = mix_state;
        print.pixel_byte_count = pixel_total[CountField-1:0];
        print.combined_key     = fnv_state ^ {mix_state[40:0], mix_state[63:41]}
                                 ^ (hash_t'(pixel_total) * Golden);
        expected_prints.push_back(print);
        restart();
      end
    endfunction

    function void check(input result_t got);
      result_t want;
      if (expected_prints.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_prints.pop_front();
      if (got.fnv_hash !== want.fnv_hash) begin
        $display("%0t fnv_hash mismatch: expected %h actual %h",
                 $time, want.fnv_hash, got.fnv_hash);
        mismatches++;
      end
      if (got.mix_hash !== want.mix_hash) begin
        $display("%0t mix_hash mismatch: expected %h actual %h",
                 $time, want.mix_hash, got.mix_hash);
        mismatches++;
      end
      if (got.pixel_byte_count !== want.pixel_byte_count) begin
        $display("%0t pixel_byte_count mismatch: expected %h actual %h",
                 $time, want.pixel_byte_count, got.pixel_byte_count);
        mismatches++;
      end
      if (got.combined_key !== want.combined_key) begin
        $display("%0t combined_key mismatch: expected %h actual %h",
                 $time, want.combined_key, got.combined_key);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_prints.size();
    endfunction
  endclass

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = 8'd0;
  logic         s_axis_tuser  = 1'b0;
  logic         s_axis_tlast  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [239:0] m_axis_tdata;

  fingerprint_tracker tracker = new();
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned burst_left  = 0;

  dual_hash_content_fingerprint_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("dual_hash_content_fingerprint_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check(result_t'(m_axis_tdata));
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.absorb(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      end
    end
  end

  // receiver: random stall patterns with one long hold-off
  initial begin
    int unsigned mode;
    int unsigned span;
    logic        toggle;
    toggle = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    repeat (HoldOffStart) begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
      @(posedge clk_i);
    end
    m_axis_tready <= 1'b0;
    repeat (HoldOffLen) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        toggle = ~toggle;
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            m_axis_tready <= toggle;
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic pix, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 32);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= pix;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_random_stream();
    int unsigned len;
    int unsigned header_len;
    logic        noisy;
    if ($urandom_range(0, 15) == 0) begin
      len = $urandom_range(60, 160);
    end else begin
      len = $urandom_range(1, 24);
    end
    header_len = $urandom_range(0, len - 1);
    noisy      = ($urandom_range(0, 7) == 0);
    for (int unsigned k = 0; k < len; k++) begin
      send_byte(8'($urandom_range(0, 255)),
                noisy ? 1'($urandom_range(0, 1)) : (k >= header_len),
                k == len - 1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-byte streams at the byte extremes
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hff, 1'b0, 1'b1);
    // header then pixels
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'haa, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h7f, 1'b1, 1'b1);
    // all pixel bytes
    send_byte(8'hfe, 1'b1, 1'b0);
    send_byte(8'h02, 1'b1, 1'b0);
    send_byte(8'h40, 1'b1, 1'b0);
    send_byte(8'hc3, 1'b1, 1'b1);
    // no pixel bytes
    send_byte(8'h10, 1'b0, 1'b0);
    send_byte(8'h20, 1'b0, 1'b0);
    send_byte(8'h04, 1'b0, 1'b0);
    send_byte(8'h08, 1'b0, 1'b1);
    // pixel flags interleaved
    send_byte(8'h3c, 1'b1, 1'b0);
    send_byte(8'hc0, 1'b0, 1'b0);
    send_byte(8'h0f, 1'b1, 1'b0);
    send_byte(8'hf0, 1'b0, 1'b1);

    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      send_random_stream();
    end
    s_axis_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("dual_hash_content_fingerprint_top regression: pass");
    end else begin
      $display("dual_hash_content_fingerprint_top regression: fail");
    end
    $finish;
  end

endmodule
